@@ rtl/core/wed_pkg.sv @@
`default_nettype none

package wed_pkg;

    localparam int MODE_W  = 2;
    localparam int NAME_W  = 32;
    localparam int HASH_W  = 64;
    localparam int OIDX_W  = 5;
    localparam int DIST_W  = 10;
    localparam int PAIR_W  = 6;

    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

    localparam logic KIND_PAIR   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam int STEP_COST  = 10;
    localparam int PAIR_LIMIT = 32;
    localparam int DIST_MAX   = 1023;

    typedef struct packed {
        logic ok;
        logic near;
    } wed_match_t;

endpackage

`default_nettype wire

@@ rtl/core/wed_nodes.sv @@
`default_nettype none

module wed_nodes
    import wed_pkg::*;
#(
    parameter int MAX_NODES = 32,
    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we_first,
    input  wire logic              we_second,
    input  wire logic [IDX_W-1:0]  waddr,
    input  wire logic [NAME_W-1:0] wname,
    input  wire logic [HASH_W-1:0] whash,
    input  wire logic [IDX_W-1:0]  raddr_a,
    input  wire logic [IDX_W-1:0]  raddr_b,
    output wed_match_t             match
);

    logic [NAME_W+HASH_W-1:0] first_mem  [MAX_NODES];
    logic [NAME_W+HASH_W-1:0] second_mem [MAX_NODES];
    logic [NAME_W+HASH_W-1:0] first_q_reg;
    logic [NAME_W+HASH_W-1:0] second_q_reg;

    always_ff @(posedge aclk) begin
        if (we_first) begin
            first_mem[waddr] <= {wname, whash};
        end
        first_q_reg <= first_mem[raddr_a];
    end

    always_ff @(posedge aclk) begin
        if (we_second) begin
            second_mem[waddr] <= {wname, whash};
        end
        second_q_reg <= second_mem[raddr_b];
    end

    // name must agree; hash mismatch costs one tenth
    always_comb begin
        match.ok   = first_q_reg[NAME_W+HASH_W-1:HASH_W] == second_q_reg[NAME_W+HASH_W-1:HASH_W];
        match.near = first_q_reg[HASH_W-1:0] != second_q_reg[HASH_W-1:0];
    end

endmodule

`default_nettype wire

@@ rtl/core/wed_cost.sv @@
`default_nettype none

module wed_cost
    import wed_pkg::*;
#(
    parameter int MAX_NODES = 32,
    localparam int CNT_W  = $clog2(MAX_NODES + 1),
    localparam int COST_W = $clog2(20 * MAX_NODES + 1)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [CNT_W-1:0]  wrow,
    input  wire logic [CNT_W-1:0]  wcol,
    input  wire logic [COST_W-1:0] wdata,
    input  wire logic [CNT_W-1:0]  rrow,
    input  wire logic [CNT_W-1:0]  rcol,
    output logic      [COST_W-1:0] rdata
);

    localparam int SIDE      = MAX_NODES + 1;
    localparam int TAB_DEPTH = SIDE * SIDE;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);

    logic [COST_W-1:0] tab_mem [TAB_DEPTH];
    logic [COST_W-1:0] mem_q_reg;
    logic              bnd_reg;
    logic [COST_W-1:0] bval_reg;
    logic [TAB_AW-1:0] waddr;
    logic [TAB_AW-1:0] raddr;
    logic [COST_W-1:0] bval_next;

    assign waddr = TAB_AW'(TAB_AW'(wrow) * TAB_AW'(SIDE) + TAB_AW'(wcol));
    assign raddr = TAB_AW'(TAB_AW'(rrow) * TAB_AW'(SIDE) + TAB_AW'(rcol));

    // row zero and column zero are never stored; they are 10 per step
    assign bval_next = (rrow == '0) ? COST_W'(COST_W'(rcol) * COST_W'(STEP_COST))
                                    : COST_W'(COST_W'(rrow) * COST_W'(STEP_COST));

    always_ff @(posedge aclk) begin
        if (we) begin
            tab_mem[waddr] <= wdata;
        end
        mem_q_reg <= tab_mem[raddr];
        bnd_reg   <= (rrow == '0) || (rcol == '0);
        bval_reg  <= bval_next;
    end

    assign rdata = bnd_reg ? bval_reg : mem_q_reg;

endmodule

`default_nettype wire

@@ rtl/core/weighted_edit_distance_aligner_top.sv @@
// Load request (mode 0/1): accepted only while idle, no result.
// Run request: the fill computes one cell per cycle plus one turnaround state per row;
// traceback steps through TB_CUR, TB_DIAG, TB_UP and TB_DEC, up to n1+n2 steps, then reports.
// Not ready while a run is in progress; output stalls hold the traceback and the report.
// Reset clears counts, overflow flag, sequencer and output valid; node stores
// and the cost matrix are not cleared and are rebuilt before being read.
`default_nettype none

module weighted_edit_distance_aligner_top
    import wed_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [MODE_W-1:0] s_mode,
    input  wire logic [NAME_W-1:0] s_name_id,
    input  wire logic [HASH_W-1:0] s_content_hash,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_kind,
    output logic [OIDX_W-1:0]      m_first_index,
    output logic [OIDX_W-1:0]      m_second_index,
    output logic [DIST_W-1:0]      m_distance,
    output logic                   m_overflowed,
    output logic                   m_last
);

    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int COST_W = $clog2(20 * MAX_NODES + 1);
    localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SAT_W  = COST_W + DIST_W;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] ST_FILL    = 4'd1;
    localparam logic [ST_W-1:0] ST_GAP     = 4'd2;
    localparam logic [ST_W-1:0] ST_LAST    = 4'd3;
    localparam logic [ST_W-1:0] ST_TB_CUR  = 4'd4;
    localparam logic [ST_W-1:0] ST_TB_DIAG = 4'd5;
    localparam logic [ST_W-1:0] ST_TB_UP   = 4'd6;
    localparam logic [ST_W-1:0] ST_TB_DEC  = 4'd7;
    localparam logic [ST_W-1:0] ST_REPORT  = 4'd8;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [CNT_W-1:0]  n1_reg, n1_next;
    logic [CNT_W-1:0]  n2_reg, n2_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [COST_W-1:0] ten_i_reg, ten_i_next;
    logic              p_vld_reg, p_vld_next;
    logic              p_first_reg, p_first_next;
    logic [CNT_W-1:0]  p_i_reg, p_i_next;
    logic [CNT_W-1:0]  p_j_reg, p_j_next;
    logic [COST_W-1:0] p_left0_reg, p_left0_next;
    logic [COST_W-1:0] p_diag0_reg, p_diag0_next;
    logic [COST_W-1:0] left_reg, left_next;
    logic [COST_W-1:0] diag_reg, diag_next;
    logic              first_step_reg, first_step_next;
    logic [COST_W-1:0] cur_reg, cur_next;
    logic [COST_W-1:0] dg_reg, dg_next;
    wed_match_t        mt_reg, mt_next;
    logic [COST_W-1:0] dist_reg, dist_next;
    logic [PAIR_W-1:0] pair_cnt_reg, pair_cnt_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_kind_reg, m_kind_next;
    logic [OIDX_W-1:0] m_first_reg, m_first_next;
    logic [OIDX_W-1:0] m_second_reg, m_second_next;
    logic [DIST_W-1:0] m_dist_reg, m_dist_next;
    logic              m_ovf_reg, m_ovf_next;
    logic              m_last_reg, m_last_next;

    logic [CNT_W-1:0]  im1, jm1;
    logic              we_first, we_second;
    logic [IDX_W-1:0]  node_waddr;
    wed_match_t        node_match;
    logic              tab_we;
    logic [CNT_W-1:0]  tab_rrow, tab_rcol;
    logic [COST_W-1:0] tab_rd;
    logic [COST_W-1:0] c_up, c_left, c_diag, c_best, c_ins, c_mat;
    logic              out_free;
    logic [SAT_W-1:0]  dist_wide;

    assign im1      = i_reg - CNT_W'(1);
    assign jm1      = j_reg - CNT_W'(1);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    assign we_first   = s_ready && s_valid && (s_mode == MODE_FIRST)
                        && (n1_reg < CNT_W'(MAX_NODES));
    assign we_second  = s_ready && s_valid && (s_mode == MODE_SECOND)
                        && (n2_reg < CNT_W'(MAX_NODES));
    assign node_waddr = (s_mode == MODE_FIRST) ? n1_reg[IDX_W-1:0] : n2_reg[IDX_W-1:0];

    wed_nodes #(.MAX_NODES(MAX_NODES)) u_nodes (
        .aclk      (aclk),
        .we_first  (we_first),
        .we_second (we_second),
        .waddr     (node_waddr),
        .wname     (s_name_id),
        .whash     (s_content_hash),
        .raddr_a   (im1[IDX_W-1:0]),
        .raddr_b   (jm1[IDX_W-1:0]),
        .match     (node_match)
    );

    wed_cost #(.MAX_NODES(MAX_NODES)) u_cost (
        .aclk  (aclk),
        .we    (tab_we),
        .wrow  (p_i_reg),
        .wcol  (p_j_reg),
        .wdata (c_best),
        .rrow  (tab_rrow),
        .rcol  (tab_rcol),
        .rdata (tab_rd)
    );

    // cell unit: min of up+10, left+10, diag+match
    always_comb begin
        c_up   = tab_rd;
        c_left = p_first_reg ? p_left0_reg : left_reg;
        c_diag = p_first_reg ? p_diag0_reg : diag_reg;
        c_best = COST_W'(c_up + COST_W'(STEP_COST));
        c_ins  = COST_W'(c_left + COST_W'(STEP_COST));
        c_mat  = COST_W'(c_diag + COST_W'(node_match.near));
        if (c_ins < c_best) begin
            c_best = c_ins;
        end
        if (node_match.ok && (c_mat < c_best)) begin
            c_best = c_mat;
        end
        tab_we = p_vld_reg;
    end

    assign dist_wide = SAT_W'(dist_reg);

    always_comb begin
        state_next      = state_reg;
        n1_next         = n1_reg;
        n2_next         = n2_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        ten_i_next      = ten_i_reg;
        p_vld_next      = 1'b0;
        p_first_next    = p_first_reg;
        p_i_next        = p_i_reg;
        p_j_next        = p_j_reg;
        p_left0_next    = p_left0_reg;
        p_diag0_next    = p_diag0_reg;
        left_next       = left_reg;
        diag_next       = diag_reg;
        first_step_next = first_step_reg;
        cur_next        = cur_reg;
        dg_next         = dg_reg;
        mt_next         = mt_reg;
        dist_next       = dist_reg;
        pair_cnt_next   = pair_cnt_reg;
        tab_rrow        = im1;
        tab_rcol        = j_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_first_next  = m_first_reg;
        m_second_next = m_second_reg;
        m_dist_next   = m_dist_reg;
        m_ovf_next    = m_ovf_reg;
        m_last_next   = m_last_reg;

        if (p_vld_reg) begin
            left_next = c_best;
            diag_next = c_up;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        MODE_FIRST: begin
                            if (we_first) begin
                                n1_next = n1_reg + CNT_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_SECOND: begin
                            if (we_second) begin
                                n2_next = n2_reg + CNT_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_RUN: begin
                            first_step_next = 1'b1;
                            pair_cnt_next   = '0;
                            ten_i_next      = COST_W'(STEP_COST);
                            if ((n1_reg != '0) && (n2_reg != '0)) begin
                                i_next     = CNT_W'(1);
                                j_next     = CNT_W'(1);
                                state_next = ST_FILL;
                            end else begin
                                i_next     = n1_reg;
                                j_next     = n2_reg;
                                state_next = ST_TB_CUR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                p_vld_next   = 1'b1;
                p_first_next = (j_reg == CNT_W'(1));
                p_i_next     = i_reg;
                p_j_next     = j_reg;
                p_left0_next = ten_i_reg;
                p_diag0_next = COST_W'(ten_i_reg - COST_W'(STEP_COST));
                if (j_reg == n2_reg) begin
                    if (i_reg == n1_reg) begin
                        state_next = ST_LAST;
                    end else begin
                        j_next     = CNT_W'(1);
                        i_next     = i_reg + CNT_W'(1);
                        ten_i_next = COST_W'(ten_i_reg + COST_W'(STEP_COST));
                        state_next = ST_GAP;
                    end
                end else begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_GAP: begin
                state_next = ST_FILL;
            end
            ST_LAST: begin
                state_next = ST_TB_CUR;
            end
            ST_TB_CUR: begin
                tab_rrow   = i_reg;
                state_next = ST_TB_DIAG;
            end
            ST_TB_DIAG: begin
                tab_rcol = jm1;
                cur_next = tab_rd;
                mt_next  = node_match;
                if (first_step_reg) begin
                    dist_next       = tab_rd;
                    first_step_next = 1'b0;
                end
                if ((i_reg == '0) || (j_reg == '0)) begin
                    state_next = ST_REPORT;
                end else begin
                    state_next = ST_TB_UP;
                end
            end
            ST_TB_UP: begin
                dg_next    = tab_rd;
                state_next = ST_TB_DEC;
            end
            ST_TB_DEC: begin
                if (mt_reg.ok && (cur_reg == COST_W'(dg_reg + COST_W'(mt_reg.near)))) begin
                    if (pair_cnt_reg < PAIR_W'(PAIR_LIMIT)) begin
                        if (out_free) begin
                            m_valid_next  = 1'b1;
                            m_kind_next   = KIND_PAIR;
                            m_first_next  = OIDX_W'(im1);
                            m_second_next = OIDX_W'(jm1);
                            m_dist_next   = '0;
                            m_ovf_next    = 1'b0;
                            m_last_next   = 1'b0;
                            pair_cnt_next = pair_cnt_reg + PAIR_W'(1);
                            i_next        = im1;
                            j_next        = jm1;
                            state_next    = ST_TB_CUR;
                        end
                    end else begin
                        i_next     = im1;
                        j_next     = jm1;
                        state_next = ST_TB_CUR;
                    end
                end else if (cur_reg == COST_W'(tab_rd + COST_W'(STEP_COST))) begin
                    i_next     = im1;
                    state_next = ST_TB_CUR;
                end else begin
                    j_next     = jm1;
                    state_next = ST_TB_CUR;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_REPORT;
                    m_first_next  = '0;
                    m_second_next = '0;
                    m_dist_next   = (dist_wide > SAT_W'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                                 : dist_wide[DIST_W-1:0];
                    m_ovf_next    = ovf_reg;
                    m_last_next   = 1'b1;
                    n1_next       = '0;
                    n2_next       = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n1_reg      <= '0;
            n2_reg      <= '0;
            ovf_reg     <= 1'b0;
            p_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n1_reg      <= n1_next;
            n2_reg      <= n2_next;
            ovf_reg     <= ovf_next;
            p_vld_reg   <= p_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        ten_i_reg      <= ten_i_next;
        p_first_reg    <= p_first_next;
        p_i_reg        <= p_i_next;
        p_j_reg        <= p_j_next;
        p_left0_reg    <= p_left0_next;
        p_diag0_reg    <= p_diag0_next;
        left_reg       <= left_next;
        diag_reg       <= diag_next;
        first_step_reg <= first_step_next;
        cur_reg        <= cur_next;
        dg_reg         <= dg_next;
        mt_reg         <= mt_next;
        dist_reg       <= dist_next;
        pair_cnt_reg   <= pair_cnt_next;
        m_kind_reg     <= m_kind_next;
        m_first_reg    <= m_first_next;
        m_second_reg   <= m_second_next;
        m_dist_reg     <= m_dist_next;
        m_ovf_reg      <= m_ovf_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_first_index  = m_first_reg;
    assign m_second_index = m_second_reg;
    assign m_distance     = m_dist_reg;
    assign m_overflowed   = m_ovf_reg;
    assign m_last         = m_last_reg;

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !p_vld_reg)
        else $error("cell pipeline busy while accepting requests");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (n1_reg <= CNT_W'(MAX_NODES)) && (n2_reg <= CNT_W'(MAX_NODES)))
        else $error("sequence count beyond capacity");

    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPORT) && out_free |=> (n1_reg == '0) && (n2_reg == '0) && !ovf_reg)
        else $error("run end did not clear sequences");

    a_pair_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (pair_cnt_reg <= PAIR_W'(PAIR_LIMIT)))
        else $error("pair count beyond limit");

    a_last_is_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_last_reg == (m_kind_reg == KIND_REPORT)))
        else $error("last flag disagrees with result kind");

endmodule

`default_nettype wire

@@ dv/weighted_edit_distance_aligner_top_tb.sv @@
`default_nettype none

module weighted_edit_distance_aligner_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wed_pkg::*;

    localparam int NODES = 32;
    localparam int NEAR_COST = 1;
    localparam int TAIL_ITEMS = 30;
    localparam int RANDOM_LOADS = 185;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NAME_W-1:0] name;
        logic [HASH_W-1:0] hash;
    } node_req_t;

    typedef struct packed {
        logic              kind;
        logic [OIDX_W-1:0] first_index;
        logic [OIDX_W-1:0] second_index;
        logic [DIST_W-1:0] distance;
        logic              overflowed;
        logic              last;
    } align_out_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [MODE_W-1:0] s_mode = MODE_FIRST;
    logic [NAME_W-1:0] s_name_id = '0;
    logic [HASH_W-1:0] s_content_hash = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_kind;
    logic [OIDX_W-1:0] m_first_index;
    logic [OIDX_W-1:0] m_second_index;
    logic [DIST_W-1:0] m_distance;
    logic              m_overflowed;
    logic              m_last;

    weighted_edit_distance_aligner_top #(.MAX_NODES(NODES)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_name_id      (s_name_id),
        .s_content_hash (s_content_hash),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_first_index  (m_first_index),
        .m_second_index (m_second_index),
        .m_distance     (m_distance),
        .m_overflowed   (m_overflowed),
        .m_last         (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    node_req_t  load_and_run_q[$];
    align_out_t alignment_results[$];

    // mirror of the node stores
    logic [NAME_W-1:0] first_name  [NODES];
    logic [HASH_W-1:0] first_hash  [NODES];
    logic [NAME_W-1:0] second_name [NODES];
    logic [HASH_W-1:0] second_hash [NODES];
    int                first_len = 0;
    int                second_len = 0;
    logic              dropped_flag = 1'b0;

    int mismatches = 0;
    int load_total = 0;
    int loads_taken = 0;
    int loads_dropped = 0;
    int runs_taken = 0;
    int pairs_seen = 0;
    int reports_seen = 0;
    int peak_distance = 0;
    int send_gap = 0;
    int stall_left = 0;

    task automatic flag_mismatch(input string what);
        if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic align_step(input node_req_t rq);
        int         cost [0:NODES][0:NODES];
        int         i, j, best, c, total, pairs;
        align_out_t r;
        if (rq.mode == MODE_FIRST || rq.mode == MODE_SECOND) begin
            loads_taken++;
            if (rq.mode == MODE_FIRST && first_len < NODES) begin
                first_name[first_len] = rq.name;
                first_hash[first_len] = rq.hash;
                first_len++;
            end else if (rq.mode == MODE_SECOND && second_len < NODES) begin
                second_name[second_len] = rq.name;
                second_hash[second_len] = rq.hash;
                second_len++;
            end else begin
                dropped_flag = 1'b1;
                loads_dropped++;
            end
        end else if (rq.mode == MODE_RUN) begin
            runs_taken++;
            for (i = 0; i <= first_len; i++) cost[i][0] = i * STEP_COST;
            for (j = 0; j <= second_len; j++) cost[0][j] = j * STEP_COST;
            for (i = 1; i <= first_len; i++) begin
                for (j = 1; j <= second_len; j++) begin
                    best = cost[i-1][j] + STEP_COST;
                    if (cost[i][j-1] + STEP_COST < best) best = cost[i][j-1] + STEP_COST;
                    c = (first_hash[i-1] == second_hash[j-1]) ? 0 : NEAR_COST;
                    if (first_name[i-1] == second_name[j-1] && cost[i-1][j-1] + c < best)
                        best = cost[i-1][j-1] + c;
                    cost[i][j] = best;
                end
            end
            total = cost[first_len][second_len];
            i = first_len;
            j = second_len;
            pairs = 0;
            while (i > 0 && j > 0) begin
                c = (first_hash[i-1] == second_hash[j-1]) ? 0 : NEAR_COST;
                if (first_name[i-1] == second_name[j-1] && cost[i][j] == cost[i-1][j-1] + c) begin
                    if (pairs < PAIR_LIMIT) begin
                        r = '0;
                        r.kind = KIND_PAIR;
                        r.first_index = OIDX_W'(i - 1);
                        r.second_index = OIDX_W'(j - 1);
                        alignment_results.push_back(r);
                        pairs++;
                    end
                    i--;
                    j--;
                end else if (cost[i][j] == cost[i-1][j] + STEP_COST) begin
                    i--;
                end else begin
                    j--;
                end
            end
            r = '0;
            r.kind = KIND_REPORT;
            r.distance = DIST_W'((total > DIST_MAX) ? DIST_MAX : total);
            r.overflowed = dropped_flag;
            r.last = 1'b1;
            alignment_results.push_back(r);
            first_len = 0;
            second_len = 0;
            dropped_flag = 1'b0;
        end
    endtask

    task automatic push_req(input logic [MODE_W-1:0] mode, input logic [NAME_W-1:0] name,
                            input logic [HASH_W-1:0] hash);
        node_req_t rq;
        rq.mode = mode;
        rq.name = name;
        rq.hash = hash;
        load_and_run_q.push_back(rq);
        if (mode != MODE_UNUSED) load_total++;
    endtask

    // counts above NODES produce loads that get dropped
    task automatic queue_alignment(input int n1, input int n2, input int pool,
                                   input bit mixed, input bit noise);
        logic [NAME_W-1:0] names  [4];
        logic [HASH_W-1:0] hashes [3];
        logic [MODE_W-1:0] side;
        logic [NAME_W-1:0] nm;
        logic [HASH_W-1:0] hs;
        int a, b;
        foreach (names[k]) names[k] = $urandom;
        foreach (hashes[k]) hashes[k] = {$urandom, $urandom};
        a = 0;
        b = 0;
        while (a < n1 || b < n2) begin
            if (a < n1 && (b >= n2 || $urandom_range(0, 1) == 0)) begin
                side = MODE_FIRST;
                a++;
            end else begin
                side = MODE_SECOND;
                b++;
            end
            if (pool == 0 || (mixed && $urandom_range(0, 9) == 0)) begin
                nm = $urandom;
                hs = {$urandom, $urandom};
            end else begin
                nm = names[$urandom_range(0, pool - 1)];
                hs = hashes[$urandom_range(0, 2)];
            end
            push_req(side, nm, hs);
            if (noise && $urandom_range(0, 7) == 0)
                push_req(MODE_UNUSED, $urandom, {$urandom, $urandom});
        end
        push_req(MODE_RUN, $urandom, {$urandom, $urandom});
    endtask

    // request driver
    always @(posedge aclk) begin
        node_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_mode <= MODE_FIRST;
            s_name_id <= '0;
            s_content_hash <= '0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) align_step({s_mode, s_name_id, s_content_hash});
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid <= 1'b0;
                    send_gap--;
                end else if (load_and_run_q.size() > 0) begin
                    if (load_and_run_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                        s_valid <= 1'b0;
                        send_gap = $urandom_range(0, 11);
                    end else begin
                        nxt = load_and_run_q.pop_front();
                        s_valid <= 1'b1;
                        s_mode <= nxt.mode;
                        s_name_id <= nxt.name;
                        s_content_hash <= nxt.hash;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        align_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (alignment_results.size() == 0) begin
                    flag_mismatch("result arrived with nothing pending");
                end else begin
                    want = alignment_results.pop_front();
                    if (m_kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d", m_kind, want.kind));
                    if (m_first_index !== want.first_index)
                        flag_mismatch($sformatf("first_index %0d, want %0d",
                                                m_first_index, want.first_index));
                    if (m_second_index !== want.second_index)
                        flag_mismatch($sformatf("second_index %0d, want %0d",
                                                m_second_index, want.second_index));
                    if (m_distance !== want.distance)
                        flag_mismatch($sformatf("distance %0d, want %0d",
                                                m_distance, want.distance));
                    if (m_overflowed !== want.overflowed)
                        flag_mismatch($sformatf("overflowed %0d, want %0d",
                                                m_overflowed, want.overflowed));
                    if (m_last !== want.last)
                        flag_mismatch($sformatf("last %0d, want %0d", m_last, want.last));
                    if (want.kind == KIND_PAIR) begin
                        pairs_seen++;
                    end else begin
                        reports_seen++;
                        if (want.distance > peak_distance) peak_distance = want.distance;
                    end
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (load_and_run_q.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int n1, n2;
        bit big_same_done, big_apart_done;

        // empty run, single-sided runs at field extremes
        push_req(MODE_RUN, '0, '0);
        push_req(MODE_FIRST, '0, '0);
        push_req(MODE_RUN, '0, '0);
        push_req(MODE_SECOND, '1, '1);
        push_req(MODE_RUN, '1, '1);
        // exact, near and forbidden matches
        push_req(MODE_FIRST, 32'h8000_0001, 64'h8000_0000_0000_0001);
        push_req(MODE_SECOND, 32'h8000_0001, 64'h8000_0000_0000_0001);
        push_req(MODE_RUN, '0, '0);
        push_req(MODE_FIRST, 32'h7FFF_FFFE, 64'h0);
        push_req(MODE_SECOND, 32'h7FFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF);
        push_req(MODE_RUN, '0, '0);
        push_req(MODE_FIRST, 32'h0000_0001, 64'h5555_5555_5555_5555);
        push_req(MODE_SECOND, 32'h0000_0002, 64'h5555_5555_5555_5555);
        push_req(MODE_RUN, '0, '0);
        // unused mode is ignored
        push_req(MODE_UNUSED, '1, '1);
        push_req(MODE_RUN, '0, '0);
        // diagonal wins the tie against a deletion
        push_req(MODE_FIRST, 32'hA5A5_5A5A, 64'hAAAA_AAAA_AAAA_AAAA);
        push_req(MODE_FIRST, 32'hA5A5_5A5A, 64'hAAAA_AAAA_AAAA_AAAA);
        push_req(MODE_SECOND, 32'hA5A5_5A5A, 64'hAAAA_AAAA_AAAA_AAAA);
        push_req(MODE_RUN, '0, '0);

        load_total = 0;
        big_same_done = 1'b0;
        big_apart_done = 1'b0;
        while (load_total < RANDOM_LOADS) begin
            if (!big_same_done && load_total >= 30) begin
                // full on both sides with overflow, one shared name
                queue_alignment(NODES + 2, NODES + 1, 1, 1'b0, 1'b0);
                big_same_done = 1'b1;
            end else if (!big_apart_done && load_total >= 110) begin
                // full on both sides, all names distinct
                queue_alignment(NODES, NODES, 0, 1'b0, 1'b0);
                big_apart_done = 1'b1;
            end else begin
                n1 = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 6);
                n2 = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 6);
                if ($urandom_range(0, 9) == 0)
                    push_req(MODE_UNUSED, $urandom, {$urandom, $urandom});
                queue_alignment(n1, n2, $urandom_range(1, 4), 1'b1, 1'b1);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (load_and_run_q.size() != 0 || s_valid || alignment_results.size() != 0);
        repeat (64) @(posedge aclk);

        $display("Summary: %0d node loads (%0d dropped at capacity), %0d alignment runs",
                 loads_taken, loads_dropped, runs_taken);
        $display("Summary: %0d matched pairs and %0d distance reports compared, peak %0d",
                 pairs_seen, reports_seen, peak_distance);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d requests and %0d results outstanding",
                 load_and_run_q.size(), alignment_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
